>>> hdl/hll_euler_face_flux_top_defines.svh
// ----------------------------------------------------------------------------
// HLL face flux assertion macros
// Shared property forms for the port-level checks of the face flux block.
// ----------------------------------------------------------------------------
`ifndef HLL_EULER_FACE_FLUX_TOP_DEFINES_SVH
`define HLL_EULER_FACE_FLUX_TOP_DEFINES_SVH

// antecedent, then consequent a fixed number of cycles later, outside reset
`define HFF_ASSERT_DELAY(label, clk, rst, ante, cons, dly) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("hff: timed check failed");

// antecedent, then consequent on the next edge, reset included
`define HFF_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hff: next-cycle check failed");

`endif

>>> hdl/hff_pkg.sv
// ----------------------------------------------------------------------------
// HLL face flux package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package hff_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int DIV_BITS    = 32;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = DIV_BITS / DIV_STEPS;
   localparam int DIV_LATENCY = DIV_STAGES + 2;
   localparam int BACK_STAGES = 2;
   // two front stages, queue write, queue read, back stages, divider
   localparam int RSP_LATENCY = 4 + BACK_STAGES + DIV_LATENCY;

   localparam int NUM_VARS = 4;
   localparam int VAR_MASS = 0;
   localparam int VAR_NORM = 1;
   localparam int VAR_TANG = 2;
   localparam int VAR_ENER = 3;

   localparam int SIDE_L = 0;
   localparam int SIDE_R = 1;

   typedef logic signed [31:0] q_type;

   localparam q_type Q_MAX = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [1:0] {
      WAVE_LEFT,
      WAVE_RIGHT,
      WAVE_SPLIT
   } wave_type;

   typedef struct packed {
      q_type rho;
      q_type n;
      q_type t;
      q_type p;
      q_type e;
      q_type a;
      q_type ep;
   } side_type;

   typedef struct packed {
      logic     valid;
      logic     dir;
      side_type [1:0] sd;
      q_type    s_l;
      q_type    s_r;
   } stage1_type;

   typedef struct packed {
      q_type rho;
      q_type n;
      q_type t;
      q_type p;
      q_type e;
      q_type fm;
      q_type ut;
      q_type fe;
   } side2_type;

   typedef struct packed {
      logic      valid;
      logic      dir;
      wave_type  wave;
      side2_type [1:0] sd;
      q_type     s_l;
      q_type     s_r;
      q_type     ss;
   } stage2_type;

   typedef struct packed {
      logic     dir;
      wave_type wave;
      q_type [1:0][NUM_VARS-1:0] flux;
      q_type [NUM_VARS-1:0]      du;
      q_type    s_l;
      q_type    s_r;
      q_type    ss;
   } entry_type;

   typedef struct packed {
      logic v1;
      logic v2;
   } front_stat_type;

   typedef struct packed {
      logic [62:0] mag;
      logic        neg;
      logic        split;
      logic [31:0] d;
      q_type       pass;
   } div_in_type;

   function automatic logic signed [63:0] ext(input q_type a);
      return 64'(a);
   endfunction

   function automatic q_type sat32(input logic signed [63:0] x);
      q_type r;
      if (x > SAT_MAX) begin
         r = Q_MAX;
      end else if (x < SAT_MIN) begin
         r = Q_MIN;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // product floored to the fixed-point grid
   function automatic logic signed [63:0] qmul(input q_type a, input q_type b,
                                               input int unsigned shift);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> shift;
   endfunction

endpackage

>>> hdl/hff_front.sv
// ----------------------------------------------------------------------------
// HLL face flux front end
// Orients the face, forms wave speeds and per-side fluxes, classifies the face.
// ----------------------------------------------------------------------------
module hff_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   dir,
   input  logic [30:0]            density_left,
   input  logic [30:0]            density_right,
   input  logic signed [31:0]     vel_x_left,
   input  logic signed [31:0]     vel_x_right,
   input  logic signed [31:0]     vel_y_left,
   input  logic signed [31:0]     vel_y_right,
   input  logic [30:0]            pressure_left,
   input  logic [30:0]            pressure_right,
   input  logic [30:0]            energy_left,
   input  logic [30:0]            energy_right,
   input  logic [30:0]            sound_left,
   input  logic [30:0]            sound_right,
   output logic                   push_valid,
   output hff_pkg::entry_type     push_entry,
   output hff_pkg::front_stat_type stat
);
   import hff_pkg::*;

   stage1_type st1_in, st1_ff;
   stage2_type st2_in, st2_ff;

   always_comb begin
      logic [31:0]        eps;
      logic signed [63:0] lo_l, lo_r, hi_l, hi_r;
      st1_in       = '0;
      st1_in.valid = accept;
      st1_in.dir   = dir;
      st1_in.sd[SIDE_L].rho = {1'b0, density_left};
      st1_in.sd[SIDE_R].rho = {1'b0, density_right};
      st1_in.sd[SIDE_L].n   = dir ? vel_y_left  : vel_x_left;
      st1_in.sd[SIDE_R].n   = dir ? vel_y_right : vel_x_right;
      st1_in.sd[SIDE_L].t   = dir ? vel_x_left  : vel_y_left;
      st1_in.sd[SIDE_R].t   = dir ? vel_x_right : vel_y_right;
      st1_in.sd[SIDE_L].p   = {1'b0, pressure_left};
      st1_in.sd[SIDE_R].p   = {1'b0, pressure_right};
      st1_in.sd[SIDE_L].e   = {1'b0, energy_left};
      st1_in.sd[SIDE_R].e   = {1'b0, energy_right};
      st1_in.sd[SIDE_L].a   = {1'b0, sound_left};
      st1_in.sd[SIDE_R].a   = {1'b0, sound_right};
      for (int k = 0; k < 2; k++) begin
         eps = {1'b0, st1_in.sd[k].e[30:0]} + {1'b0, st1_in.sd[k].p[30:0]};
         st1_in.sd[k].ep = eps[31] ? Q_MAX : $signed(eps);
      end
      lo_l = ext(st1_in.sd[SIDE_L].n) - ext(st1_in.sd[SIDE_L].a);
      lo_r = ext(st1_in.sd[SIDE_R].n) - ext(st1_in.sd[SIDE_R].a);
      hi_l = ext(st1_in.sd[SIDE_L].n) + ext(st1_in.sd[SIDE_L].a);
      hi_r = ext(st1_in.sd[SIDE_R].n) + ext(st1_in.sd[SIDE_R].a);
      st1_in.s_l = sat32((lo_l < lo_r) ? lo_l : lo_r);
      st1_in.s_r = sat32((hi_l > hi_r) ? hi_l : hi_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '0;
      end else begin
         st1_ff <= st1_in;
      end
   end

   always_comb begin
      st2_in       = '0;
      st2_in.valid = st1_ff.valid;
      st2_in.dir   = st1_ff.dir;
      st2_in.s_l   = st1_ff.s_l;
      st2_in.s_r   = st1_ff.s_r;
      st2_in.ss    = sat32(qmul(st1_ff.s_l, st1_ff.s_r, FRAC_BITS));
      for (int k = 0; k < 2; k++) begin
         st2_in.sd[k].rho = st1_ff.sd[k].rho;
         st2_in.sd[k].n   = st1_ff.sd[k].n;
         st2_in.sd[k].t   = st1_ff.sd[k].t;
         st2_in.sd[k].p   = st1_ff.sd[k].p;
         st2_in.sd[k].e   = st1_ff.sd[k].e;
         st2_in.sd[k].fm  = sat32(qmul(st1_ff.sd[k].rho, st1_ff.sd[k].n, FRAC_BITS));
         st2_in.sd[k].ut  = sat32(qmul(st1_ff.sd[k].rho, st1_ff.sd[k].t, FRAC_BITS));
         st2_in.sd[k].fe  = sat32(qmul(st1_ff.sd[k].n, st1_ff.sd[k].ep, FRAC_BITS));
      end
      // left wins a tie at zero
      priority if (!st1_ff.s_l[31]) begin
         st2_in.wave = WAVE_LEFT;
      end else if (st1_ff.s_r[31] || (st1_ff.s_r == '0)) begin
         st2_in.wave = WAVE_RIGHT;
      end else begin
         st2_in.wave = WAVE_SPLIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff <= '0;
      end else begin
         st2_ff <= st2_in;
      end
   end

   always_comb begin
      push_entry      = '0;
      push_entry.dir  = st2_ff.dir;
      push_entry.wave = st2_ff.wave;
      push_entry.s_l  = st2_ff.s_l;
      push_entry.s_r  = st2_ff.s_r;
      push_entry.ss   = st2_ff.ss;
      for (int k = 0; k < 2; k++) begin
         push_entry.flux[k][VAR_MASS] = st2_ff.sd[k].fm;
         push_entry.flux[k][VAR_NORM] =
            sat32(qmul(st2_ff.sd[k].fm, st2_ff.sd[k].n, FRAC_BITS) + ext(st2_ff.sd[k].p));
         push_entry.flux[k][VAR_TANG] =
            sat32(qmul(st2_ff.sd[k].fm, st2_ff.sd[k].t, FRAC_BITS));
         push_entry.flux[k][VAR_ENER] = st2_ff.sd[k].fe;
      end
      push_entry.du[VAR_MASS] =
         sat32(ext(st2_ff.sd[SIDE_R].rho) - ext(st2_ff.sd[SIDE_L].rho));
      push_entry.du[VAR_NORM] =
         sat32(ext(st2_ff.sd[SIDE_R].fm) - ext(st2_ff.sd[SIDE_L].fm));
      push_entry.du[VAR_TANG] =
         sat32(ext(st2_ff.sd[SIDE_R].ut) - ext(st2_ff.sd[SIDE_L].ut));
      push_entry.du[VAR_ENER] =
         sat32(ext(st2_ff.sd[SIDE_R].e) - ext(st2_ff.sd[SIDE_L].e));
   end

   assign push_valid = st2_ff.valid;
   assign stat.v1    = st1_ff.valid;
   assign stat.v2    = st2_ff.valid;

endmodule

>>> hdl/hff_queue.sv
// ----------------------------------------------------------------------------
// HLL face flux queue
// Small FIFO of classified faces between front and back end.
// ----------------------------------------------------------------------------
module hff_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hff_pkg::entry_type          push_entry,
   output logic                        pop,
   output hff_pkg::entry_type          head,
   output logic [hff_pkg::QCOUNT_W-1:0] count
);
   import hff_pkg::*;

   entry_type            mem_ff [QUEUE_DEPTH];
   entry_type            head_ff;
   logic                 pop_ff;
   logic                 rd_en;
   logic [QPTR_W-1:0]    wptr_ff, wptr_in;
   logic [QPTR_W-1:0]    rptr_ff, rptr_in;
   logic [QCOUNT_W-1:0]  count_ff, count_in;

   // back end never stalls, so the head leaves as soon as it is there
   assign rd_en = (count_ff != '0);
   assign pop   = pop_ff;
   assign head  = head_ff;
   assign count = count_ff;

   always_comb begin
      wptr_in  = push  ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = rd_en ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCOUNT_W'(push) - QCOUNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
      if (rd_en) begin
         head_ff <= mem_ff[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
         pop_ff   <= 1'b0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
         pop_ff   <= rd_en;
      end
   end

endmodule

>>> hdl/hff_div.sv
// ----------------------------------------------------------------------------
// HLL face flux divider lane
// Pipelined restoring division of the scaled numerator, saturated result.
// ----------------------------------------------------------------------------
module hff_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  hff_pkg::div_in_type lane_in,
   output hff_pkg::q_type      result
);
   import hff_pkg::*;

   localparam int NW = 63 + FRAC_BITS;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] acc;
      logic [31:0] d;
      logic        ovf;
      logic        neg;
      logic        split;
      q_type       pass;
   } step_type;

   logic [NW-1:0]    num_sh;
   logic [NW-33:0]   hi;
   step_type         st0;
   step_type         st_ff  [DIV_STAGES+1];
   step_type         nxt    [DIV_STAGES+1];
   q_type            res_in, res_ff;

   always_comb begin
      num_sh    = {lane_in.mag, {FRAC_BITS{1'b0}}};
      hi        = num_sh[NW-1:32];
      st0.rem   = hi[31:0];
      st0.acc   = num_sh[31:0];
      st0.d     = lane_in.d;
      // quotient would need more than 32 bits
      st0.ovf   = (hi >= (NW-32)'(lane_in.d));
      st0.neg   = lane_in.neg;
      st0.split = lane_in.split;
      st0.pass  = lane_in.pass;
   end

   always_comb begin
      logic [32:0] trial;
      logic [31:0] r, a;
      nxt[0] = st0;
      for (int i = 1; i <= DIV_STAGES; i++) begin
         nxt[i] = st_ff[i-1];
         r = st_ff[i-1].rem;
         a = st_ff[i-1].acc;
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {r, a[31]};
            a     = {a[30:0], 1'b0};
            if (trial >= {1'b0, st_ff[i-1].d}) begin
               trial = trial - {1'b0, st_ff[i-1].d};
               a[0]  = 1'b1;
            end
            r = trial[31:0];
         end
         nxt[i].rem = r;
         nxt[i].acc = a;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
         st_ff[i] <= nxt[i];
      end
   end

   always_comb begin
      logic [31:0] q;
      q = st_ff[DIV_STAGES].acc;
      if (!st_ff[DIV_STAGES].split) begin
         res_in = st_ff[DIV_STAGES].pass;
      end else if (!st_ff[DIV_STAGES].neg) begin
         res_in = (st_ff[DIV_STAGES].ovf || q[31]) ? Q_MAX : $signed(q);
      end else if (st_ff[DIV_STAGES].ovf || (q > 32'h8000_0000)) begin
         res_in = Q_MIN;
      end else begin
         res_in = $signed(32'd0 - q);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

>>> hdl/hff_back.sv
// ----------------------------------------------------------------------------
// HLL face flux back end
// Forms the HLL numerators, divides by the wave-speed spread, drives results.
// ----------------------------------------------------------------------------
module hff_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop,
   input  hff_pkg::entry_type head,
   output logic               rsp_valid,
   output hff_pkg::q_type     rsp_mass_flux,
   output hff_pkg::q_type     rsp_momentum_x_flux,
   output hff_pkg::q_type     rsp_momentum_y_flux,
   output hff_pkg::q_type     rsp_energy_flux
);
   import hff_pkg::*;

   localparam int PIPE_LEN = BACK_STAGES + DIV_LATENCY;

   typedef struct packed {
      logic                        split;
      logic [31:0]                 d;
      logic [NUM_VARS-1:0][63:0]   pa;
      logic [NUM_VARS-1:0][63:0]   pb;
      logic [NUM_VARS-1:0][63:0]   pc;
      q_type [NUM_VARS-1:0]        pass;
   } prod_type;

   typedef struct packed {
      logic valid;
      logic dir;
   } tag_type;

   prod_type    b1_in, b1_ff;
   div_in_type  lane_in [NUM_VARS];
   div_in_type  lane_ff [NUM_VARS];
   q_type       res     [NUM_VARS];
   tag_type     tag_ff  [PIPE_LEN];

   always_comb begin
      logic signed [63:0] spread;
      spread   = ext(head.s_r) - ext(head.s_l);
      b1_in.d  = spread[31:0];
      b1_in.split = (head.wave == WAVE_SPLIT);
      for (int k = 0; k < NUM_VARS; k++) begin
         b1_in.pa[k]   = qmul(head.s_r, head.flux[SIDE_L][k], FRAC_BITS);
         b1_in.pb[k]   = qmul(head.s_l, head.flux[SIDE_R][k], FRAC_BITS);
         b1_in.pc[k]   = qmul(head.ss, head.du[k], FRAC_BITS);
         b1_in.pass[k] = (head.wave == WAVE_LEFT) ? head.flux[SIDE_L][k]
                                                   : head.flux[SIDE_R][k];
      end
   end

   always_ff @(posedge clock) begin
      b1_ff <= b1_in;
   end

   always_comb begin
      logic signed [63:0] num, mag;
      for (int k = 0; k < NUM_VARS; k++) begin
         num = $signed(b1_ff.pa[k]) - $signed(b1_ff.pb[k]) + $signed(b1_ff.pc[k]);
         mag = num[63] ? -num : num;
         lane_in[k].mag   = mag[62:0];
         lane_in[k].neg   = num[63];
         lane_in[k].split = b1_ff.split;
         lane_in[k].d     = b1_ff.d;
         lane_in[k].pass  = b1_ff.pass[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_VARS; k++) begin
         lane_ff[k] <= lane_in[k];
      end
   end

   for (genvar k = 0; k < NUM_VARS; k++) begin : g_lane
      hff_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .lane_in (lane_ff[k]),
         .result  (res[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag_ff[0].valid <= pop;
         tag_ff[0].dir   <= head.dir;
         for (int i = 1; i < PIPE_LEN; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign rsp_valid           = tag_ff[PIPE_LEN-1].valid;
   assign rsp_mass_flux       = res[VAR_MASS];
   assign rsp_momentum_x_flux = tag_ff[PIPE_LEN-1].dir ? res[VAR_TANG] : res[VAR_NORM];
   assign rsp_momentum_y_flux = tag_ff[PIPE_LEN-1].dir ? res[VAR_NORM] : res[VAR_TANG];
   assign rsp_energy_flux     = res[VAR_ENER];

endmodule

>>> hdl/hll_euler_face_flux_top.sv
// ----------------------------------------------------------------------------
// HLL face flux, top level
// HLL flux of a 2D Euler cell face in signed fixed point, one face per clock if not busy.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------
//  request   | start in, busy out        | req_* : both face states
//  response  | rsp_valid strobe out      | rsp_* : four saturated fluxes
//  csr       | csr_valid in, csr_ready   | csr_wdata : face direction
//
//  A face is taken on every cycle with start high and busy low; its fluxes
//  appear on rsp_* for a single cycle, with rsp_valid high. A face passes
//  through the two front stages, the queue write and registered read, two
//  product stages and the 32-bit restoring divider at four quotient bits
//  per stage.
//  Synchronous reset empties the pipeline and queue and clears direction.
//  The receiver cannot stall; busy rises only if the queue would overfill.
// ----------------------------------------------------------------------------
module hll_euler_face_flux_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [30:0]        req_density_left,
   input  logic [30:0]        req_density_right,
   input  logic signed [31:0] req_vel_x_left,
   input  logic signed [31:0] req_vel_x_right,
   input  logic signed [31:0] req_vel_y_left,
   input  logic signed [31:0] req_vel_y_right,
   input  logic [30:0]        req_pressure_left,
   input  logic [30:0]        req_pressure_right,
   input  logic [30:0]        req_energy_left,
   input  logic [30:0]        req_energy_right,
   input  logic [30:0]        req_sound_left,
   input  logic [30:0]        req_sound_right,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mass_flux,
   output logic signed [31:0] rsp_momentum_x_flux,
   output logic signed [31:0] rsp_momentum_y_flux,
   output logic signed [31:0] rsp_energy_flux,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);
   import hff_pkg::*;

   logic                 dir_ff;
   logic                 accept;
   logic                 push_valid;
   entry_type            push_entry;
   front_stat_type       stat;
   logic                 pop;
   entry_type            head;
   logic [QCOUNT_W-1:0]  count;
   logic [QCOUNT_W:0]    load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         dir_ff <= csr_wdata;
      end
   end

   // faces already in the front stages still need a queue slot
   assign load   = {1'b0, count} + (QCOUNT_W+1)'(stat.v1) + (QCOUNT_W+1)'(stat.v2);
   assign busy   = (load >= (QCOUNT_W+1)'(QUEUE_DEPTH));
   assign accept = start && !busy;

   hff_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .dir            (dir_ff),
      .density_left   (req_density_left),
      .density_right  (req_density_right),
      .vel_x_left     (req_vel_x_left),
      .vel_x_right    (req_vel_x_right),
      .vel_y_left     (req_vel_y_left),
      .vel_y_right    (req_vel_y_right),
      .pressure_left  (req_pressure_left),
      .pressure_right (req_pressure_right),
      .energy_left    (req_energy_left),
      .energy_right   (req_energy_right),
      .sound_left     (req_sound_left),
      .sound_right    (req_sound_right),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .stat           (stat)
   );

   hff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .count      (count)
   );

   hff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop                 (pop),
      .head                (head),
      .rsp_valid           (rsp_valid),
      .rsp_mass_flux       (rsp_mass_flux),
      .rsp_momentum_x_flux (rsp_momentum_x_flux),
      .rsp_momentum_y_flux (rsp_momentum_y_flux),
      .rsp_energy_flux     (rsp_energy_flux)
   );

endmodule

>>> hdl/hff_check.sv
// ----------------------------------------------------------------------------
// HLL face flux port checks
// Latency and reset behaviour as seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "hll_euler_face_flux_top_defines.svh"

module hff_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import hff_pkg::*;

   // every accepted transaction comes back after the fixed latency
   `HFF_ASSERT_DELAY(a_rsp_follows_req, clock, reset, start && !busy, rsp_valid, RSP_LATENCY)
   // no response without a matching accepted request
   `HFF_ASSERT_DELAY(a_no_spurious_rsp, clock, reset, rsp_valid, $past(start && !busy, RSP_LATENCY), 0)
   // reset flushes the pipeline and the queue
   `HFF_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid && !busy)

endmodule

bind hll_euler_face_flux_top hff_check u_hff_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
